### sv/lzom_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzom_pkg
// Shared constants, codes and word types of the layer z-order manager.
// ---------------------------------------------------------------------------
package lzom_pkg;

    localparam int MAX_LAYERS  = 256;
    localparam int LAYER_AW    = $clog2(MAX_LAYERS);
    localparam int COUNT_BITS  = LAYER_AW + 1;
    localparam int HEIGHT_BITS = LAYER_AW + 1;
    localparam int ID_BITS     = 8;
    localparam int COORD_BITS  = 12;
    localparam int EDGE_BITS   = COORD_BITS + 1;
    localparam int OP_BITS     = 3;
    localparam int S_TDATA_BITS = 72;
    localparam int M_TDATA_BITS = 72;

    localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_HIDDEN = '1;
    localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_TOP_MAX = HEIGHT_BITS'(MAX_LAYERS - 1);
    localparam logic SHEET_USE = 1'b1;

    typedef enum logic [OP_BITS-1:0] {
        OP_ALLOC      = 3'd0,
        OP_FREE       = 3'd1,
        OP_SET_HEIGHT = 3'd2,
        OP_SET_SIZE   = 3'd3,
        OP_MOVE       = 3'd4,
        OP_DIRTY      = 3'd5
    } op_t;

    typedef struct packed {
        op_t                           op;
        logic [ID_BITS-1:0]            sheet_id;
        logic signed [HEIGHT_BITS-1:0] target_height;
        logic signed [COORD_BITS-1:0]  x0;
        logic signed [COORD_BITS-1:0]  y0;
        logic signed [COORD_BITS-1:0]  x1;
        logic signed [COORD_BITS-1:0]  y1;
    } req_t;

    typedef struct packed {
        logic                          status;
        logic [ID_BITS-1:0]            sheet_out;
        logic signed [HEIGHT_BITS-1:0] height_out;
        logic                          redraw;
        logic signed [EDGE_BITS-1:0]   rect_x0;
        logic signed [EDGE_BITS-1:0]   rect_y0;
        logic signed [EDGE_BITS-1:0]   rect_x1;
        logic signed [EDGE_BITS-1:0]   rect_y1;
        logic                          last;
    } res_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] size_w;
        logic signed [COORD_BITS-1:0] size_h;
    } geom_t;

    typedef struct packed {
        logic                we;
        logic [LAYER_AW-1:0] waddr;
        logic [LAYER_AW-1:0] wdata;
        logic [LAYER_AW-1:0] raddr;
    } ot_req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a;
        logic signed [COORD_BITS-1:0] b;
    } alu_req_t;

endpackage

### sv/lzom_edge_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzom_edge_alu
// Shared registered adder that builds one rectangle edge per cycle.
// ---------------------------------------------------------------------------
module lzom_edge_alu (
    input  logic                                     aclk,
    input  lzom_pkg::alu_req_t                       req,
    output logic signed [lzom_pkg::EDGE_BITS-1:0]    sum
);

    logic signed [lzom_pkg::EDGE_BITS-1:0] sum_reg;
    logic signed [lzom_pkg::EDGE_BITS-1:0] sum_next;

    // sign-extend both operands by one bit, add
    assign sum_next = $signed({req.a[lzom_pkg::COORD_BITS-1], req.a})
                    + $signed({req.b[lzom_pkg::COORD_BITS-1], req.b});

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

### sv/lzom_order_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzom_order_table
// Height-to-layer table: one write port, one registered read port.
// ---------------------------------------------------------------------------
module lzom_order_table (
    input  logic                             aclk,
    input  lzom_pkg::ot_req_t                req,
    output logic [lzom_pkg::LAYER_AW-1:0]    rdata
);

    logic [lzom_pkg::LAYER_AW-1:0] mem [lzom_pkg::MAX_LAYERS];
    logic [lzom_pkg::LAYER_AW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/lzom_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzom_sequencer
// Request sequencer: layer pool, height and geometry stores, order shifts.
// ---------------------------------------------------------------------------
module lzom_sequencer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  lzom_pkg::req_t                        in_req,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output lzom_pkg::res_t                        res,
    output lzom_pkg::ot_req_t                     ot_req,
    input  logic [lzom_pkg::LAYER_AW-1:0]         ot_rdata,
    output lzom_pkg::alu_req_t                    alu_req,
    input  logic signed [lzom_pkg::EDGE_BITS-1:0] alu_sum
);

    localparam int HB = lzom_pkg::HEIGHT_BITS;
    localparam int AW = lzom_pkg::LAYER_AW;
    localparam int NL = lzom_pkg::MAX_LAYERS;
    localparam logic [2:0] EDGE_STEPS = 3'd4;
    localparam logic signed [HB:0] WIDE_HIDDEN = '1;
    localparam logic signed [HB:0] WIDE_ONE    = (HB+1)'(1);
    localparam logic signed [HB:0] WIDE_TOPMAX = (HB+1)'(NL - 1);
    localparam logic [AW-1:0]      LAST_IDX    = AW'(NL - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_CHK,
        ST_PREP,
        ST_SHIFT,
        ST_FINAL,
        ST_RECT,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    lzom_pkg::req_t          req_reg;
    lzom_pkg::res_t          res_reg;
    logic [AW-1:0]           cnt_reg;
    logic [NL-1:0]           used_reg;
    logic [NL-1:0]           gvalid_reg;
    logic signed [HB-1:0]    top_reg;
    logic signed [HB-1:0]    h_old_reg;
    logic signed [HB-1:0]    h_new_reg;
    lzom_pkg::geom_t         geom_reg;
    logic signed [lzom_pkg::COORD_BITS-1:0] base_x_reg, base_y_reg;
    logic signed [lzom_pkg::COORD_BITS-1:0] off_x0_reg, off_y0_reg, off_x1_reg, off_y1_reg;
    logic [AW-1:0]           rd_idx_reg, wr_idx_reg;
    logic [lzom_pkg::COUNT_BITS-1:0] rem_reg;
    logic                    pend_reg, up_reg, final_reg, top_inc_reg, top_dec_reg;
    logic [2:0]              edge_reg;
    logic                    second_reg;

    // height and geometry stores
    logic signed [HB-1:0]    hmem [NL];
    logic signed [HB-1:0]    hmem_rd_reg;
    logic                    hm_we;
    logic [AW-1:0]           hm_waddr;
    logic signed [HB-1:0]    hm_wdata;
    lzom_pkg::geom_t         gmem [NL];
    lzom_pkg::geom_t         gmem_rd_reg;
    logic                    gm_we;
    lzom_pkg::geom_t         gm_wdata;

    logic [AW-1:0]           id_idx;
    logic                    in_pool;
    logic                    live;
    logic                    shown;
    lzom_pkg::geom_t         geom_cur;
    lzom_pkg::res_t          plain_res;

    logic signed [HB:0]      tgt_w, top_w, tp1_w, old_rd_w, clamp_w;
    logic signed [HB-1:0]    h_new_c;
    logic signed [HB:0]      old_w, new_w, p_w, q_w, n_w, ws_w;
    logic                    plan_up, plan_final, plan_inc, plan_dec, plan_c;
    logic [AW-1:0]           step_wr;

    assign id_idx  = AW'(req_reg.sheet_id);
    assign in_pool = (32'(req_reg.sheet_id) < NL);
    assign live    = in_pool && used_reg[id_idx];
    assign shown   = !hmem_rd_reg[HB-1];
    assign geom_cur = gvalid_reg[id_idx] ? gmem_rd_reg : '0;

    always_comb begin
        plain_res            = '0;
        plain_res.sheet_out  = req_reg.sheet_id;
        plain_res.height_out = live ? hmem_rd_reg : lzom_pkg::HEIGHT_HIDDEN;
        plain_res.last       = 1'b1;
    end

    // clamp the requested height
    always_comb begin
        old_rd_w = {hmem_rd_reg[HB-1], hmem_rd_reg};
        top_w    = {top_reg[HB-1], top_reg};
        tp1_w    = top_w + WIDE_ONE;
        tgt_w    = (req_reg.op == lzom_pkg::OP_FREE) ? WIDE_HIDDEN
                 : {req_reg.target_height[HB-1], req_reg.target_height};
        clamp_w  = tgt_w;
        if (clamp_w > tp1_w) begin
            clamp_w = tp1_w;
        end
        if (!old_rd_w[HB] && clamp_w > top_w) begin
            clamp_w = top_w;
        end
        if (clamp_w < WIDE_HIDDEN) begin
            clamp_w = WIDE_HIDDEN;
        end
        if (clamp_w > WIDE_TOPMAX) begin
            clamp_w = WIDE_TOPMAX;
        end
        h_new_c = clamp_w[HB-1:0];
    end

    // plan the order table shift: start, direction, length, closing write
    always_comb begin
        old_w      = {h_old_reg[HB-1], h_old_reg};
        new_w      = {h_new_reg[HB-1], h_new_reg};
        p_w        = old_w;
        q_w        = new_w;
        plan_c     = 1'b0;
        ws_w       = old_w;
        plan_up    = 1'b0;
        plan_final = 1'b1;
        plan_inc   = 1'b0;
        plan_dec   = 1'b0;
        if (old_w > new_w) begin
            if (!new_w[HB]) begin
                // lower a shown layer: pull entries up into the gap
                p_w = old_w;
                q_w = new_w;
            end else begin
                // hide: close the gap above the old height
                p_w        = top_w;
                q_w        = old_w;
                plan_up    = 1'b1;
                plan_final = 1'b0;
                plan_dec   = 1'b1;
            end
        end else if (!old_w[HB]) begin
            // raise a shown layer
            p_w     = new_w;
            q_w     = old_w;
            plan_up = 1'b1;
        end else begin
            // show a hidden layer: open a slot at the new height
            p_w      = top_w;
            q_w      = new_w;
            plan_c   = 1'b1;
            ws_w     = tp1_w;
            plan_inc = 1'b1;
        end
        n_w = p_w - q_w + (plan_c ? WIDE_ONE : '0);
    end

    assign step_wr = ws_w[AW-1:0];

    // store write ports
    always_comb begin
        hm_we    = 1'b0;
        hm_waddr = cnt_reg;
        hm_wdata = lzom_pkg::HEIGHT_HIDDEN;
        case (state_reg)
            ST_SCAN: begin
                hm_we = !used_reg[cnt_reg];
            end
            ST_PREP: begin
                hm_we    = 1'b1;
                hm_waddr = id_idx;
                hm_wdata = h_new_reg;
            end
            ST_SHIFT: begin
                hm_we    = pend_reg;
                hm_waddr = ot_rdata;
                hm_wdata = HB'(wr_idx_reg);
            end
            default: begin
                hm_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        gm_we    = (state_reg == ST_CHK) && live
                 && (req_reg.op == lzom_pkg::OP_MOVE || req_reg.op == lzom_pkg::OP_SET_SIZE);
        gm_wdata = geom_cur;
        if (req_reg.op == lzom_pkg::OP_MOVE) begin
            gm_wdata.pos_x = req_reg.x0;
            gm_wdata.pos_y = req_reg.y0;
        end else begin
            gm_wdata.size_w = req_reg.x1;
            gm_wdata.size_h = req_reg.y1;
        end
    end

    always_ff @(posedge aclk) begin
        if (hm_we) begin
            hmem[hm_waddr] <= hm_wdata;
        end
        hmem_rd_reg <= hmem[id_idx];
    end

    always_ff @(posedge aclk) begin
        if (gm_we) begin
            gmem[id_idx] <= gm_wdata;
        end
        gmem_rd_reg <= gmem[id_idx];
    end

    // order table port
    always_comb begin
        ot_req       = '0;
        ot_req.raddr = rd_idx_reg;
        if (state_reg == ST_SHIFT && pend_reg) begin
            ot_req.we    = 1'b1;
            ot_req.waddr = wr_idx_reg;
            ot_req.wdata = ot_rdata;
        end else if (state_reg == ST_FINAL && final_reg) begin
            ot_req.we    = 1'b1;
            ot_req.waddr = h_new_reg[AW-1:0];
            ot_req.wdata = id_idx;
        end
    end

    // edge operands: left, top, right, bottom
    always_comb begin
        case (edge_reg)
            3'd0: begin
                alu_req.a = base_x_reg;
                alu_req.b = off_x0_reg;
            end
            3'd1: begin
                alu_req.a = base_y_reg;
                alu_req.b = off_y0_reg;
            end
            3'd2: begin
                alu_req.a = base_x_reg;
                alu_req.b = off_x1_reg;
            end
            default: begin
                alu_req.a = base_y_reg;
                alu_req.b = off_y1_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            gvalid_reg  <= '0;
            top_reg     <= lzom_pkg::HEIGHT_HIDDEN;
            pend_reg    <= 1'b0;
            second_reg  <= 1'b0;
            edge_reg    <= '0;
        end else begin
            if (gm_we) begin
                gvalid_reg[id_idx] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        req_reg   <= in_req;
                        cnt_reg   <= '0;
                        state_reg <= (in_req.op == lzom_pkg::OP_ALLOC) ? ST_SCAN : ST_RD;
                    end
                end
                ST_SCAN: begin
                    if (!used_reg[cnt_reg]) begin
                        used_reg[cnt_reg]  <= lzom_pkg::SHEET_USE;
                        res_reg            <= '0;
                        res_reg.sheet_out  <= lzom_pkg::ID_BITS'(cnt_reg);
                        res_reg.height_out <= lzom_pkg::HEIGHT_HIDDEN;
                        res_reg.last       <= 1'b1;
                        state_reg          <= ST_EMIT;
                    end else if (cnt_reg == LAST_IDX) begin
                        res_reg            <= '0;
                        res_reg.status     <= 1'b1;
                        res_reg.height_out <= lzom_pkg::HEIGHT_HIDDEN;
                        res_reg.last       <= 1'b1;
                        state_reg          <= ST_EMIT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    geom_reg   <= geom_cur;
                    h_old_reg  <= hmem_rd_reg;
                    h_new_reg  <= h_new_c;
                    base_x_reg <= geom_cur.pos_x;
                    base_y_reg <= geom_cur.pos_y;
                    off_x0_reg <= '0;
                    off_y0_reg <= '0;
                    off_x1_reg <= geom_cur.size_w;
                    off_y1_reg <= geom_cur.size_h;
                    edge_reg   <= '0;
                    res_reg    <= plain_res;
                    state_reg  <= ST_EMIT;
                    if (live) begin
                        case (req_reg.op)
                            lzom_pkg::OP_FREE: begin
                                used_reg[id_idx]   <= 1'b0;
                                res_reg.height_out <= lzom_pkg::HEIGHT_HIDDEN;
                                if (shown) begin
                                    state_reg <= ST_PREP;
                                end
                            end
                            lzom_pkg::OP_SET_HEIGHT: begin
                                if (h_new_c != hmem_rd_reg) begin
                                    state_reg <= ST_PREP;
                                end
                            end
                            lzom_pkg::OP_MOVE: begin
                                if (shown) begin
                                    res_reg.last <= 1'b0;
                                    second_reg   <= 1'b1;
                                    state_reg    <= ST_RECT;
                                end
                            end
                            lzom_pkg::OP_DIRTY: begin
                                if (shown) begin
                                    off_x0_reg <= req_reg.x0;
                                    off_y0_reg <= req_reg.y0;
                                    off_x1_reg <= req_reg.x1;
                                    off_y1_reg <= req_reg.y1;
                                    state_reg  <= ST_RECT;
                                end
                            end
                            default: begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_PREP: begin
                    wr_idx_reg  <= step_wr;
                    rd_idx_reg  <= plan_up ? step_wr + 1'b1 : step_wr - 1'b1;
                    rem_reg     <= n_w[lzom_pkg::COUNT_BITS-1:0];
                    up_reg      <= plan_up;
                    final_reg   <= plan_final;
                    top_inc_reg <= plan_inc;
                    top_dec_reg <= plan_dec;
                    pend_reg    <= 1'b0;
                    state_reg   <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    // retire the entry read last cycle, issue the next read
                    if (pend_reg) begin
                        wr_idx_reg <= up_reg ? wr_idx_reg + 1'b1 : wr_idx_reg - 1'b1;
                    end
                    if (rem_reg != '0) begin
                        rd_idx_reg <= up_reg ? rd_idx_reg + 1'b1 : rd_idx_reg - 1'b1;
                        rem_reg    <= rem_reg - 1'b1;
                        pend_reg   <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                        if (!pend_reg) begin
                            state_reg <= ST_FINAL;
                        end
                    end
                end
                ST_FINAL: begin
                    if (top_inc_reg) begin
                        top_reg <= top_reg + 1'b1;
                    end else if (top_dec_reg) begin
                        top_reg <= top_reg - 1'b1;
                    end
                    res_reg.height_out <= h_new_reg;
                    edge_reg           <= '0;
                    state_reg          <= ST_RECT;
                end
                ST_RECT: begin
                    edge_reg <= edge_reg + 1'b1;
                    case (edge_reg)
                        3'd1: begin
                            res_reg.rect_x0 <= alu_sum;
                        end
                        3'd2: begin
                            res_reg.rect_y0 <= alu_sum;
                        end
                        3'd3: begin
                            res_reg.rect_x1 <= alu_sum;
                        end
                        EDGE_STEPS: begin
                            res_reg.rect_y1 <= alu_sum;
                            res_reg.redraw  <= 1'b1;
                            state_reg       <= ST_EMIT;
                        end
                        default: begin
                            res_reg.redraw <= res_reg.redraw;
                        end
                    endcase
                end
                ST_EMIT: begin
                    if (res_ready) begin
                        if (second_reg) begin
                            // move: the new rectangle follows the old one
                            base_x_reg   <= req_reg.x0;
                            base_y_reg   <= req_reg.y0;
                            second_reg   <= 1'b0;
                            res_reg.last <= 1'b1;
                            edge_reg     <= '0;
                            state_reg    <= ST_RECT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer ready straight after taking a request");

    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= lzom_pkg::HEIGHT_TOP_MAX)
        else $error("top height beyond the pool");

    a_quiet_rect: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res.redraw) |->
        (res.rect_x0 == '0 && res.rect_y0 == '0 && res.rect_x1 == '0 && res.rect_y1 == '0))
        else $error("rectangle fields set without redraw");

    a_pool_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status) |->
        (res.sheet_out == '0 && res.height_out == lzom_pkg::HEIGHT_HIDDEN && !res.redraw))
        else $error("bad pool-full result");

endmodule

### sv/layer_z_order_manager_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// layer_z_order_manager_unit
// Window layer pool and z-order stack with dirty rectangle reporting.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel, one word per request; the op code
//   travels in s_tuser. Each request yields one result word on the m_
//   channel, or two for a move of a shown layer (old rectangle, then new);
//   m_tlast marks the final word of a request.
//   The block handles one request at a time and drops s_tready meanwhile.
//   Allocate scans the pool for a free layer (up to 256 layers, lowest
//   free layer wins). A height change or free of a shown layer moves
//   order table entries (up to 255) through the single order table
//   port. Each rectangle is built edge by edge on the shared edge adder.
//   Results sit in an output register; while m_tready is low the word is
//   held and the sequencer waits, but once the last word is registered the
//   next request is taken.
//   Reset: all layers free and hidden, positions and sizes zero, no layer
//   shown. Reset takes effect at once; no clearing pass.
// ---------------------------------------------------------------------------
module layer_z_order_manager_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sheet_id[7:0], target_height[16:8], x0[28:17], y0[40:29],
    // x1[52:41], y1[64:53], zero fill above
    input  logic [lzom_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // op[2:0]
    input  logic [lzom_pkg::OP_BITS-1:0]         s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sheet_out[7:0], height_out[16:8], rect_x0[29:17], rect_y0[42:30],
    // rect_x1[55:43], rect_y1[68:56], zero fill above
    output logic [lzom_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // status[0], redraw[1]
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);

    lzom_pkg::req_t     s_req;
    lzom_pkg::res_t     seq_res;
    logic               seq_res_valid;
    logic               seq_res_ready;
    lzom_pkg::ot_req_t  ot_req;
    logic [lzom_pkg::LAYER_AW-1:0] ot_rdata;
    lzom_pkg::alu_req_t alu_req;
    logic signed [lzom_pkg::EDGE_BITS-1:0] alu_sum;

    lzom_pkg::res_t     m_res_reg;
    logic               m_tvalid_reg;

    // unpack the request word
    always_comb begin
        s_req.op            = lzom_pkg::op_t'(s_tuser);
        s_req.sheet_id      = s_tdata[7:0];
        s_req.target_height = s_tdata[16:8];
        s_req.x0            = s_tdata[28:17];
        s_req.y0            = s_tdata[40:29];
        s_req.x1            = s_tdata[52:41];
        s_req.y1            = s_tdata[64:53];
    end

    lzom_edge_alu u_alu (
        .aclk (aclk),
        .req  (alu_req),
        .sum  (alu_sum)
    );

    lzom_order_table u_order (
        .aclk  (aclk),
        .req   (ot_req),
        .rdata (ot_rdata)
    );

    lzom_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_req),
        .res_valid (seq_res_valid),
        .res_ready (seq_res_ready),
        .res       (seq_res),
        .ot_req    (ot_req),
        .ot_rdata  (ot_rdata),
        .alu_req   (alu_req),
        .alu_sum   (alu_sum)
    );

    // output register: take a new word when empty or being drained
    assign seq_res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (seq_res_ready) begin
            m_tvalid_reg <= seq_res_valid;
        end
    end

    // hold the payload while the receiver stalls
    always_ff @(posedge aclk) begin
        if (seq_res_valid && seq_res_ready) begin
            m_res_reg <= seq_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_res_reg.rect_y1, m_res_reg.rect_x1, m_res_reg.rect_y0,
                       m_res_reg.rect_x0, m_res_reg.height_out, m_res_reg.sheet_out};
    assign m_tuser  = {m_res_reg.redraw, m_res_reg.status};
    assign m_tlast  = m_res_reg.last;

endmodule

### test/layer_z_order_manager_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// layer_z_order_manager_unit_tb
// Self-checking bench for the layer pool and z-order stack.
// A queue of requests (a short directed set, a full-pool fill and drain,
// then random traffic on a handful of live layers) is streamed into the
// block. The bench keeps its own copy of the layer pool and stacking order,
// works out the result words for every accepted request and checks each
// result word in order. Both sides idle at random in rotating phases, and
// the receiver once holds off for a long stretch to back the block up.
// ---------------------------------------------------------------------------
module layer_z_order_manager_unit_tb;

    import lzom_pkg::*;

    // spare op codes that the block must ignore
    localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;

    localparam int DRAIN_CYCLES = 600;    // longest request plus margin
    localparam int HOLD_AT      = 200;    // requests taken before the hold-off
    localparam int HOLD_CYCLES  = 800;
    localparam int PHASE_LEN    = 120;    // requests per idling phase
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [OP_BITS-1:0]            op;
        logic [ID_BITS-1:0]            sheet_id;
        logic signed [HEIGHT_BITS-1:0] target_height;
        logic signed [COORD_BITS-1:0]  x0;
        logic signed [COORD_BITS-1:0]  y0;
        logic signed [COORD_BITS-1:0]  x1;
        logic signed [COORD_BITS-1:0]  y1;
    } layer_req_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [OP_BITS-1:0]      s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [1:0]              m_tuser;
    logic                    m_tlast;

    layer_z_order_manager_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Own copy of the layer pool and stacking order
    // -----------------------------------------------------------------------
    bit                           lay_used [MAX_LAYERS];
    int                           lay_h    [MAX_LAYERS];
    logic [ID_BITS-1:0]           z_slot   [MAX_LAYERS];
    int                           top_h;
    logic signed [COORD_BITS-1:0] lay_px   [MAX_LAYERS];
    logic signed [COORD_BITS-1:0] lay_py   [MAX_LAYERS];
    logic signed [COORD_BITS-1:0] lay_w    [MAX_LAYERS];
    logic signed [COORD_BITS-1:0] lay_hgt  [MAX_LAYERS];

    res_t       due_words [$];       // result words still to arrive
    layer_req_t pending_reqs [$];    // requests not yet offered
    layer_req_t on_bus;

    int reqs_taken  = 0;
    int total_reqs  = 0;
    int fault_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    // generator's view of which layers are allocated
    bit gen_live [MAX_LAYERS];
    int live_count = 0;

    initial begin
        for (int i = 0; i < MAX_LAYERS; i++) begin
            lay_used[i] = 1'b0;
            lay_h[i]    = -1;
            z_slot[i]   = '0;
            lay_px[i]   = '0;
            lay_py[i]   = '0;
            lay_w[i]    = '0;
            lay_hgt[i]  = '0;
            gen_live[i] = 1'b0;
        end
        top_h = -1;
    end

    function automatic res_t make_word(bit status, int sheet, int height, bit redraw,
                                       int rx0, int ry0, int rx1, int ry1, bit last);
        res_t w;
        w.status     = status;
        w.sheet_out  = ID_BITS'(sheet);
        w.height_out = HEIGHT_BITS'(height);
        w.redraw     = redraw;
        w.rect_x0    = redraw ? EDGE_BITS'(rx0) : '0;
        w.rect_y0    = redraw ? EDGE_BITS'(ry0) : '0;
        w.rect_x1    = redraw ? EDGE_BITS'(rx1) : '0;
        w.rect_y1    = redraw ? EDGE_BITS'(ry1) : '0;
        w.last       = last;
        return w;
    endfunction

    function automatic void seat(int k, logic [ID_BITS-1:0] id);
        z_slot[k] = id;
        lay_h[id] = k;
    endfunction

    // Clamp the wanted height and shift the order entries; report a change.
    function automatic bit restack(int id, int h);
        int old;
        old = lay_h[id];
        if (h > top_h + 1)
            h = top_h + 1;
        // a layer already shown can rise no higher than the top
        if (old >= 0 && h > top_h)
            h = top_h;
        if (h < -1)
            h = -1;
        if (h >= MAX_LAYERS)
            h = MAX_LAYERS - 1;
        if (old == h)
            return 1'b0;
        lay_h[id] = h;
        if (old > h) begin
            if (h >= 0) begin
                for (int k = old; k > h; k--)
                    seat(k, z_slot[k-1]);
                seat(h, ID_BITS'(id));
            end else begin
                for (int k = old; k < top_h; k++)
                    seat(k, z_slot[k+1]);
                top_h--;
            end
        end else begin
            if (old >= 0) begin
                for (int k = old; k < h; k++)
                    seat(k, z_slot[k+1]);
                seat(h, ID_BITS'(id));
            end else begin
                for (int k = top_h; k >= h; k--)
                    seat(k + 1, z_slot[k]);
                seat(h, ID_BITS'(id));
                top_h++;
            end
        end
        return 1'b1;
    endfunction

    // Apply one accepted request and queue the result words it causes.
    task automatic stack_apply(input layer_req_t r);
        int id, px, py, sw, sh;
        bit changed;
        bit found;
        id    = r.sheet_id;
        found = 1'b0;
        if (r.op == OP_ALLOC) begin
            for (int i = 0; i < MAX_LAYERS && !found; i++) begin
                if (!lay_used[i]) begin
                    found       = 1'b1;
                    lay_used[i] = SHEET_USE;
                    lay_h[i]    = -1;
                    due_words.push_back(make_word(0, i, -1, 0, 0, 0, 0, 0, 1));
                end
            end
            // pool full
            if (!found)
                due_words.push_back(make_word(1, 0, -1, 0, 0, 0, 0, 0, 1));
            return;
        end
        // any other request on a free layer is dropped
        if (!lay_used[id]) begin
            due_words.push_back(make_word(0, id, -1, 0, 0, 0, 0, 0, 1));
            return;
        end
        px = lay_px[id];
        py = lay_py[id];
        sw = lay_w[id];
        sh = lay_hgt[id];
        case (r.op)
            OP_FREE: begin
                changed = 1'b0;
                if (lay_h[id] >= 0)
                    changed = restack(id, -1);
                lay_used[id] = 1'b0;
                due_words.push_back(make_word(0, id, -1, changed,
                                              px, py, px + sw, py + sh, 1));
            end
            OP_SET_HEIGHT: begin
                changed = restack(id, int'(r.target_height));
                due_words.push_back(make_word(0, id, lay_h[id], changed,
                                              px, py, px + sw, py + sh, 1));
            end
            OP_SET_SIZE: begin
                lay_w[id]   = r.x1;
                lay_hgt[id] = r.y1;
                due_words.push_back(make_word(0, id, lay_h[id], 0, 0, 0, 0, 0, 1));
            end
            OP_MOVE: begin
                lay_px[id] = r.x0;
                lay_py[id] = r.y0;
                if (lay_h[id] >= 0) begin
                    due_words.push_back(make_word(0, id, lay_h[id], 1,
                                                  px, py, px + sw, py + sh, 0));
                    px = lay_px[id];
                    py = lay_py[id];
                    due_words.push_back(make_word(0, id, lay_h[id], 1,
                                                  px, py, px + sw, py + sh, 1));
                end else begin
                    due_words.push_back(make_word(0, id, lay_h[id], 0, 0, 0, 0, 0, 1));
                end
            end
            OP_DIRTY: begin
                due_words.push_back(make_word(0, id, lay_h[id], lay_h[id] >= 0,
                                              px + int'(r.x0), py + int'(r.y0),
                                              px + int'(r.x1), py + int'(r.y1), 1));
            end
            default: begin
                due_words.push_back(make_word(0, id, lay_h[id], 0, 0, 0, 0, 0, 1));
            end
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Stimulus generation
    // -----------------------------------------------------------------------
    task automatic queue_req(input logic [OP_BITS-1:0] op, input int id, input int th,
                             input int a0, input int b0, input int a1, input int b1);
        layer_req_t r;
        bit found;
        r.op            = op;
        r.sheet_id      = ID_BITS'(id);
        r.target_height = HEIGHT_BITS'(th);
        r.x0            = COORD_BITS'(a0);
        r.y0            = COORD_BITS'(b0);
        r.x1            = COORD_BITS'(a1);
        r.y1            = COORD_BITS'(b1);
        pending_reqs.push_back(r);
        // track allocation so that later requests can aim at live layers
        found = 1'b0;
        if (op == OP_ALLOC) begin
            for (int i = 0; i < MAX_LAYERS && !found; i++) begin
                if (!gen_live[i]) begin
                    gen_live[i] = 1'b1;
                    live_count++;
                    found = 1'b1;
                end
            end
        end else if (op == OP_FREE && gen_live[r.sheet_id]) begin
            gen_live[r.sheet_id] = 1'b0;
            live_count--;
        end
    endtask

    function automatic int pick_live();
        int n;
        if (live_count == 0)
            return $urandom_range(0, MAX_LAYERS - 1);
        n = $urandom_range(0, live_count - 1);
        for (int i = 0; i < MAX_LAYERS; i++) begin
            if (gen_live[i]) begin
                if (n == 0)
                    return i;
                n--;
            end
        end
        return 0;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0:       return -2048;
            1:       return 2047;
            2:       return $urandom_range(0, 64) - 32;
            default: return int'($signed(COORD_BITS'($urandom)));
        endcase
    endfunction

    function automatic int rand_height();
        if ($urandom_range(0, 3) == 0)
            return int'($signed(HEIGHT_BITS'($urandom)));
        return $urandom_range(0, 34) - 2;
    endfunction

    task automatic build_requests();
        int order [MAX_LAYERS];
        int j, tmp, roll, id;
        logic [OP_BITS-1:0] op;

        // directed opening: extremes, every op, clamping and ignored cases
        queue_req(OP_ALLOC, 0, 0, 0, 0, 0, 0);
        queue_req(OP_ALLOC, 0, 0, 0, 0, 0, 0);
        queue_req(OP_SET_SIZE, 0, 0, 0, 0, 2047, 2047);
        queue_req(OP_SET_SIZE, 1, 0, 0, 0, -2048, -2048);
        queue_req(OP_MOVE, 0, 0, 2047, -2048, 0, 0);           // hidden: no rectangle
        queue_req(OP_SET_HEIGHT, 0, 255, 0, 0, 0, 0);          // clamp to top plus one
        queue_req(OP_SET_HEIGHT, 1, -256, 0, 0, 0, 0);         // clamp to hidden, no change
        queue_req(OP_SET_HEIGHT, 1, 0, 0, 0, 0, 0);            // insert below
        queue_req(OP_SET_HEIGHT, 1, 255, 0, 0, 0, 0);          // shown: clamp to top
        queue_req(OP_MOVE, 0, 0, -2048, 2047, 0, 0);           // shown: old and new
        queue_req(OP_DIRTY, 0, 0, -2048, -2048, 2047, 2047);
        queue_req(OP_DIRTY, 2, 0, 1, 1, 5, 5);                 // free layer
        queue_req(OP_SET_HEIGHT, 0, -1, 0, 0, 0, 0);           // hide
        queue_req(OP_DIRTY, 0, 0, 0, 0, 10, 10);               // hidden layer
        queue_req(OP_SPARE_A, 1, 3, 7, 7, 7, 7);
        queue_req(OP_SPARE_B, 1, -3, -7, -7, -7, -7);
        queue_req(OP_SPARE_B, 255, 0, 0, 0, 0, 0);
        queue_req(OP_FREE, 1, 0, 0, 0, 0, 0);                  // free while shown
        queue_req(OP_FREE, 0, 0, 0, 0, 0, 0);                  // free while hidden
        queue_req(OP_FREE, 0, 0, 0, 0, 0, 0);                  // already free
        queue_req(OP_ALLOC, 0, 0, 0, 0, 0, 0);                 // geometry kept
        queue_req(OP_SET_HEIGHT, 0, 0, 0, 0, 0, 0);
        queue_req(OP_SET_HEIGHT, 0, 0, 0, 0, 0, 0);            // same height
        queue_req(OP_SET_SIZE, 0, 0, 0, 0, 0, -1);

        // fill the whole pool, overflow it, stack every layer, then drain
        while (live_count < MAX_LAYERS)
            queue_req(OP_ALLOC, 0, 0, 0, 0, 0, 0);
        queue_req(OP_ALLOC, 0, 0, 0, 0, 0, 0);
        queue_req(OP_ALLOC, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < MAX_LAYERS; i++)
            queue_req(OP_SET_HEIGHT, i, 255, rand_coord(), rand_coord(),
                      rand_coord(), rand_coord());
        for (int i = 0; i < 16; i++)
            queue_req(OP_SET_HEIGHT, $urandom_range(0, MAX_LAYERS - 1),
                      $urandom_range(0, MAX_LAYERS - 1), 0, 0, 0, 0);
        for (int i = 0; i < MAX_LAYERS; i++)
            order[i] = i;
        for (int i = MAX_LAYERS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < MAX_LAYERS; i++)
            queue_req(OP_FREE, order[i], rand_height(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord());

        // random traffic on a small set of live layers, with some noise
        for (int i = 0; i < 700; i++) begin
            roll = $urandom_range(0, 99);
            id   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LAYERS - 1)
                                                : pick_live();
            if (roll < 12)
                op = (live_count < 20) ? OP_ALLOC : OP_SET_HEIGHT;
            else if (roll < 19)
                op = OP_FREE;
            else if (roll < 44)
                op = OP_SET_HEIGHT;
            else if (roll < 54)
                op = OP_SET_SIZE;
            else if (roll < 72)
                op = OP_MOVE;
            else if (roll < 90)
                op = OP_DIRTY;
            else if (roll < 94)
                op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
            else begin
                op = OP_BITS'($urandom_range(0, 7));
                id = $urandom_range(0, MAX_LAYERS - 1);
            end
            queue_req(op, id, rand_height(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord());
        end
    endtask

    // -----------------------------------------------------------------------
    // Idling: rotate through no idling, sender idle, receiver stall, both
    // -----------------------------------------------------------------------
    function automatic int idle_phase();
        return (reqs_taken / PHASE_LEN) % 4;
    endfunction

    function automatic bit sender_rests();
        case (idle_phase())
            1:       return $urandom_range(0, 99) < 88;
            3:       return $urandom_range(0, 99) < 27;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (idle_phase())
            2:       return $urandom_range(0, 99) < 88;
            3:       return $urandom_range(0, 99) < 27;
            default: return 1'b0;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Driver: hold the word until taken, then advance to the next one
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                stack_apply(on_bus);
                reqs_taken <= reqs_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && !sender_rests()) begin
                    on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_BITS'({on_bus.y1, on_bus.x1, on_bus.y0, on_bus.x0,
                                               on_bus.target_height, on_bus.sheet_id});
                    s_tuser  <= on_bus.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side, counted here so the sender keeps
    // offering words and the block backs up onto its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reqs_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && !receiver_rests();
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: check each result word against the oldest one due
    // -----------------------------------------------------------------------
    task automatic log_fault(input string what, input res_t want, input res_t got);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("%t %s", $realtime, what);
            $display("  want st=%0d id=%0d h=%0d rd=%0d rect=(%0d,%0d)-(%0d,%0d) last=%0d",
                     want.status, want.sheet_out, want.height_out, want.redraw,
                     want.rect_x0, want.rect_y0, want.rect_x1, want.rect_y1, want.last);
            $display("  got  st=%0d id=%0d h=%0d rd=%0d rect=(%0d,%0d)-(%0d,%0d) last=%0d",
                     got.status, got.sheet_out, got.height_out, got.redraw,
                     got.rect_x0, got.rect_y0, got.rect_x1, got.rect_y1, got.last);
        end
    endtask

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = m_tuser[0];
            got.redraw     = m_tuser[1];
            got.sheet_out  = m_tdata[7:0];
            got.height_out = m_tdata[16:8];
            got.rect_x0    = m_tdata[29:17];
            got.rect_y0    = m_tdata[42:30];
            got.rect_x1    = m_tdata[55:43];
            got.rect_y1    = m_tdata[68:56];
            got.last       = m_tlast;
            if (due_words.size() == 0) begin
                log_fault("result word with none due", '0, got);
            end else begin
                want = due_words.pop_front();
                if (got !== want)
                    log_fault("result word mismatch", want, got);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence: build the requests, reset, wait for the drain, report
    // -----------------------------------------------------------------------
    initial begin
        build_requests();
        total_reqs = pending_reqs.size();
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(reqs_taken == total_reqs && due_words.size() == 0))
            @(posedge aclk);
        // let any stray word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0 && due_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
